### design/fpp_pkg.sv
package fpp_pkg;

    // Reply characters the parser reacts to
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Reply code must be exactly this many characters
    localparam logic [2:0] CODE_CHARS = 3'd3;
    // Character counters saturate here
    localparam logic [2:0] COUNT_MAX = 3'd7;

    // Default longest port field, in characters
    localparam int FIELD_CHARS_DEF = 3;

    // Field values are clamped at 256, so nine bits hold them
    localparam int VAL_W = 9;
    localparam logic [VAL_W-1:0] VAL_CLAMP = 9'd256;
    localparam int ACC_W = 12;
    localparam logic [ACC_W-1:0] BYTE_MAX = 12'd255;

    typedef enum logic [6:0] {
        PH_CODE  = 7'b0000001,
        PH_SKIP1 = 7'b0000010,
        PH_SKIP2 = 7'b0000100,
        PH_SKIP3 = 7'b0001000,
        PH_SKIP4 = 7'b0010000,
        PH_HIGH  = 7'b0100000,
        PH_LOW   = 7'b1000000
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_CODE  = 2'd1,
        ST_BAD_FIELD = 2'd2
    } status_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] port;
        status_t     status;
    } result_t;

endpackage

### design/fpp_core.sv
module fpp_core #(
    parameter int FIELD_CHARS = fpp_pkg::FIELD_CHARS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [7:0]       rx_char,
    output fpp_pkg::result_t res
);
    import fpp_pkg::*;

    localparam logic [2:0] FIELD_LIMIT = 3'(FIELD_CHARS);

    phase_t           phase_reg, phase_next;
    logic [2:0]       count_reg, count_next;
    logic [VAL_W-1:0] high_reg, high_next;
    logic [VAL_W-1:0] low_reg, low_next;
    logic             ended_reg, ended_next;
    logic             begun_reg, begun_next;
    logic             ovf_reg, ovf_next;

    // One field character, atoi style
    logic [VAL_W-1:0] fld_val;
    logic [VAL_W-1:0] fc_val;
    logic [ACC_W-1:0] acc;
    logic [2:0]       fc_count;
    logic             fc_ovf;
    logic             fc_ended;
    logic             fc_begun;
    logic             is_digit;

    always_comb
    begin
        fld_val  = (phase_reg == PH_LOW) ? low_reg : high_reg;
        is_digit = rx_char inside {[CH_ZERO:CH_NINE]};
        acc      = ACC_W'(fld_val) * ACC_W'(10) + ACC_W'(rx_char[3:0]);
        fc_count = (count_reg < COUNT_MAX) ? count_reg + 3'd1 : count_reg;
        fc_ovf   = ovf_reg || (fc_count > FIELD_LIMIT);
        fc_val   = fld_val;
        fc_ended = ended_reg;
        fc_begun = begun_reg;
        if (!ended_reg)
        begin
            if (is_digit)
            begin
                fc_begun = 1'b1;
                if (acc > BYTE_MAX)
                begin
                    fc_ovf = 1'b1;
                    fc_val = VAL_CLAMP;
                end
                else
                begin
                    fc_val = acc[VAL_W-1:0];
                end
            end
            else if (!(rx_char == CH_SPACE && !begun_reg))
            begin
                fc_ended = 1'b1;
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        high_next  = high_reg;
        low_next   = low_reg;
        ended_next = ended_reg;
        begun_next = begun_reg;
        ovf_next   = ovf_reg;
        res.hit    = 1'b0;
        res.port   = '0;
        res.status = ST_OK;

        case (phase_reg)
            PH_SKIP1, PH_SKIP2, PH_SKIP3, PH_SKIP4:
            begin
                if (rx_char == CH_COMMA)
                begin
                    case (phase_reg)
                        PH_SKIP1: phase_next = PH_SKIP2;
                        PH_SKIP2: phase_next = PH_SKIP3;
                        PH_SKIP3: phase_next = PH_SKIP4;
                        default:  phase_next = PH_HIGH;
                    endcase
                    count_next = '0;
                    ended_next = 1'b0;
                    begun_next = 1'b0;
                end
            end
            PH_HIGH:
            begin
                if (rx_char == CH_COMMA)
                begin
                    phase_next = PH_LOW;
                    count_next = '0;
                    ended_next = 1'b0;
                    begun_next = 1'b0;
                end
                else
                begin
                    count_next = fc_count;
                    ovf_next   = fc_ovf;
                    ended_next = fc_ended;
                    begun_next = fc_begun;
                    high_next  = fc_val;
                end
            end
            PH_LOW:
            begin
                if (rx_char == CH_CLOSE)
                begin
                    res.hit = 1'b1;
                    if (ovf_reg)
                    begin
                        res.status = ST_BAD_FIELD;
                    end
                    else
                    begin
                        res.port = {high_reg[7:0], low_reg[7:0]};
                    end
                    phase_next = PH_CODE;
                    count_next = '0;
                    high_next  = '0;
                    low_next   = '0;
                    ended_next = 1'b0;
                    begun_next = 1'b0;
                    ovf_next   = 1'b0;
                end
                else
                begin
                    count_next = fc_count;
                    ovf_next   = fc_ovf;
                    ended_next = fc_ended;
                    begun_next = fc_begun;
                    low_next   = fc_val;
                end
            end
            default:
            begin
                // Reply code: count characters up to the first space
                if (rx_char == CH_SPACE)
                begin
                    if (count_reg != CODE_CHARS)
                    begin
                        res.hit    = 1'b1;
                        res.status = ST_BAD_CODE;
                        phase_next = PH_CODE;
                        high_next  = '0;
                        low_next   = '0;
                        ovf_next   = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_SKIP1;
                    end
                    count_next = '0;
                    ended_next = 1'b0;
                    begun_next = 1'b0;
                end
                else if (count_reg < COUNT_MAX)
                begin
                    count_next = count_reg + 3'd1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CODE;
            count_reg <= '0;
            high_reg  <= '0;
            low_reg   <= '0;
            ended_reg <= 1'b0;
            begun_reg <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else if (en)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            high_reg  <= high_next;
            low_reg   <= low_next;
            ended_reg <= ended_next;
            begun_reg <= begun_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

### design/ftp_passive_port_parser.sv
// FTP passive-mode reply port parser.
//
// Input channel (rx_valid / rx_stall / rx_byte): one reply character per beat,
// e.g. "227 Entering Passive Mode (h1,h2,h3,h4,p1,p2)". A beat is taken at a
// rising edge with rx_valid high and rx_stall low.
// Result channel (res_valid / res_stall / port / status): one beat per reply,
// issued on the closing parenthesis, or on the first space when the reply
// code is not three characters long (status 1). status 2 flags a port field
// longer than FIELD_CHARS characters or a value above 255; port is zero
// whenever status is not 0. Bytes that end nothing give no result beat.
// Timing: a byte goes into an input register and is parsed from there once
// the output register is free; its result is written into the output register
// at the edge that parses the byte. Unless res_stall holds a result, one byte
// per cycle is taken back to back; the output register decouples the two sides.
// When res_stall holds a result, the parser stops and the input register
// fills; rx_stall then rises until the result beat leaves.
// Reset (rst_n low, asynchronous) drops any held byte and result and returns
// the parser to waiting for a reply code.
module ftp_passive_port_parser #(
    parameter int FIELD_CHARS = fpp_pkg::FIELD_CHARS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [15:0] port,
    output logic [1:0]  status
);
    import fpp_pkg::*;

    logic        byte_valid_reg;
    logic [7:0]  byte_reg;
    logic        res_valid_reg;
    logic [15:0] port_reg;
    logic [1:0]  status_reg;

    logic        out_free;
    logic        advance;
    logic        rx_take;
    result_t     core_res;

    // Output register can take a new result when empty or draining this cycle
    assign out_free = !res_valid_reg || !res_stall;
    // Parse the held byte when its result (if any) has somewhere to go
    assign advance  = byte_valid_reg && out_free;
    assign rx_stall = byte_valid_reg && !out_free;
    assign rx_take  = rx_valid && !rx_stall;

    fpp_core #(
        .FIELD_CHARS(FIELD_CHARS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (advance),
        .rx_char (byte_reg),
        .res     (core_res)
    );

    // Input register: hold while stalled, drop once parsed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (rx_take)
        begin
            byte_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            byte_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            byte_reg <= rx_byte;
        end
    end

    // Result register: advance on a parsed byte, hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            res_valid_reg <= advance && core_res.hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && core_res.hit)
        begin
            port_reg   <= core_res.port;
            status_reg <= core_res.status;
        end
    end

    assign res_valid = res_valid_reg;
    assign port      = port_reg;
    assign status    = status_reg;

    // A parsed byte that closes a reply must show up as a result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && core_res.hit) |=> res_valid_reg)
    else $error("parsed result did not reach the output register");

    // Stall toward the sender only while a byte is held
    assert property (@(posedge clk) disable iff (!rst_n)
        rx_stall |-> byte_valid_reg)
    else $error("input stalled with no byte held");

    // Any error status carries a zero port
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && status_reg != ST_OK) |-> (port_reg == 16'd0))
    else $error("error result with nonzero port");

endmodule

### tb/tb_ftp_passive_port_parser.sv
`timescale 1ns / 100ps

module tb_ftp_passive_port_parser;

    import fpp_pkg::*;

    // Stimulus sizing and run limits
    localparam int FIELD_LEN    = FIELD_CHARS_DEF;
    localparam int CODE_LEN     = 3;
    localparam int BYTE_TARGET  = 1050;
    localparam int CALM_TAIL    = 150;
    localparam int PAUSE_EVERY  = 300;
    localparam int SETTLE       = 16;
    localparam int QUIET_LIMIT  = 2000;
    localparam int PORT_SCALE   = 256;
    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 11;

    // Extra reply characters used only to build stimulus
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef struct {
        logic [15:0] port;
        status_t     status;
    } port_beat_t;

    // Tracks the parser state one character at a time and keeps the port
    // beats that the block still owes us, oldest first.
    class pasv_port_tracker;
        phase_t      phase;
        logic [2:0]  char_count;
        logic [9:0]  high_value;
        logic [9:0]  low_value;
        bit          number_ended;
        bit          number_begun;
        bit          field_overflow;
        port_beat_t  ports_due[$];
        int          errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            phase          = PH_CODE;
            char_count     = '0;
            high_value     = '0;
            low_value      = '0;
            number_ended   = 1'b0;
            number_begun   = 1'b0;
            field_overflow = 1'b0;
        endfunction

        function void open_field();
            char_count   = '0;
            number_ended = 1'b0;
            number_begun = 1'b0;
        endfunction

        // One port-field character: count it, then fold it in atoi style
        function logic [9:0] field_char(logic [7:0] c, logic [9:0] value);
            int acc;
            if (char_count != COUNT_MAX)
                char_count++;
            if (int'(char_count) > FIELD_LEN)
                field_overflow = 1'b1;
            if (number_ended)
                return value;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                acc = int'(value) * 10 + int'(c - CH_ZERO);
                number_begun = 1'b1;
                if (acc > int'(BYTE_MAX)) begin
                    field_overflow = 1'b1;
                    acc = int'(VAL_CLAMP);
                end
                return 10'(acc);
            end
            if (!(c == CH_SPACE && !number_begun))
                number_ended = 1'b1;
            return value;
        endfunction

        function void take_char(logic [7:0] c);
            port_beat_t beat;
            case (phase)
                PH_SKIP1, PH_SKIP2, PH_SKIP3, PH_SKIP4: begin
                    if (c == CH_COMMA) begin
                        phase = phase_t'(phase << 1);
                        open_field();
                    end
                end
                PH_HIGH: begin
                    if (c == CH_COMMA) begin
                        phase = PH_LOW;
                        open_field();
                    end
                    else
                        high_value = field_char(c, high_value);
                end
                PH_LOW: begin
                    if (c == CH_CLOSE) begin
                        if (field_overflow) begin
                            beat.port   = '0;
                            beat.status = ST_BAD_FIELD;
                        end
                        else begin
                            beat.port   = 16'(int'(high_value) * PORT_SCALE + int'(low_value));
                            beat.status = ST_OK;
                        end
                        ports_due.push_back(beat);
                        clear();
                    end
                    else
                        low_value = field_char(c, low_value);
                end
                default: begin
                    if (c == CH_SPACE) begin
                        if (char_count != CODE_CHARS) begin
                            beat.port   = '0;
                            beat.status = ST_BAD_CODE;
                            ports_due.push_back(beat);
                            clear();
                        end
                        else begin
                            phase = PH_SKIP1;
                            open_field();
                        end
                    end
                    else if (char_count != COUNT_MAX)
                        char_count++;
                end
            endcase
        endfunction

        function void match_port(logic [15:0] got_port, logic [1:0] got_status);
            port_beat_t want;
            if (ports_due.size() == 0) begin
                $error("unexpected result beat: port %0d status %0d", got_port, got_status);
                errors++;
                return;
            end
            want = ports_due.pop_front();
            if (got_port !== want.port) begin
                $error("port: expected %0d, got %0d", want.port, got_port);
                errors++;
            end
            if (got_status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got_status);
                errors++;
            end
        endfunction

        function int pending();
            return ports_due.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        rx_valid;
    logic        rx_stall;
    logic [7:0]  rx_byte;
    logic        res_valid;
    logic        res_stall;
    logic [15:0] port;
    logic [1:0]  status;

    pasv_port_tracker tracker = new();

    logic [7:0] reply_q[$];
    bit         idle_on;
    int         sent;
    int         quiet;

    ftp_passive_port_parser #(
        .FIELD_CHARS (FIELD_LEN)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .port      (port),
        .status    (status)
    );

    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    // Result side: check every beat that leaves the block. Reads here see the
    // values from before the edge, since everything is driven nonblocking.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            tracker.match_port(port, status);
    end

    // Result side back-pressure: hold res_stall high in bursts, started at random
    // while idling is on.
    initial
    begin
        res_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && idle_on && $urandom_range(0, 5) == 0) begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves a beat
    always @(posedge clk)
    begin
        if (!rst_n || (rx_valid && !rx_stall) || (res_valid && !res_stall))
            quiet <= 0;
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        wait (quiet >= QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // Offer one byte, optionally after an idle burst, and hold it until taken.
    // The beat is taken at the first edge that sees rx_stall low.
    task automatic send_byte(input logic [7:0] c);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            rx_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= c;
        do
            @(posedge clk);
        while (rx_stall);
        tracker.take_char(c);
        sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Drop valid and wait until every owed port beat has come out
    task automatic drain();
        rx_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
    endtask

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++)
            reply_q.push_back(s[i]);
    endfunction

    function automatic logic [7:0] other_char(logic [7:0] a, logic [7:0] b);
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == a || c == b);
        return c;
    endfunction

    function automatic logic [7:0] stop_char();
        case ($urandom_range(0, 3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_NUL;
            default: return other_char(CH_COMMA, CH_CLOSE);
        endcase
    endfunction

    // One port field: mostly a clean number, sometimes padded, cut short,
    // signed, too large, too long or plain junk.
    function automatic void push_field();
        int kind;
        int value;
        kind = $urandom_range(0, 11);
        case (kind)
            6: begin
                repeat ($urandom_range(1, 2)) reply_q.push_back(CH_SPACE);
                push_str($sformatf("%0d", $urandom_range(0, 99)));
            end
            7: begin
                push_str($sformatf("%0d", $urandom_range(0, 99)));
                reply_q.push_back(stop_char());
            end
            8: push_str($sformatf("%0d", $urandom_range(256, 999)));
            9: begin
                reply_q.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                push_str($sformatf("%0d", $urandom_range(0, 99)));
            end
            10: repeat ($urandom_range(0, 5)) reply_q.push_back(other_char(CH_COMMA, CH_CLOSE));
            11: repeat ($urandom_range(1, 5)) reply_q.push_back(CH_ZERO);
            default: begin
                if ($urandom_range(0, 3) == 0)
                    value = $urandom_range(0, 1) ? 255 : 0;
                else
                    value = $urandom_range(0, 255);
                push_str($sformatf("%0d", value));
            end
        endcase
    endfunction

    // Build one reply into reply_q. Most are well formed with random content;
    // the rest are noise, bad codes, truncated or unclosed replies.
    function automatic void build_reply();
        int mode;
        int code_len;
        reply_q.delete();
        mode = $urandom_range(0, 19);
        if (mode < 2) begin
            repeat ($urandom_range(1, 16)) reply_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        code_len = (mode == 2) ? $urandom_range(0, 8) : CODE_LEN;
        repeat (code_len) begin
            if ($urandom_range(0, 3) == 0)
                reply_q.push_back(other_char(CH_SPACE, CH_SPACE));
            else
                reply_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        end
        reply_q.push_back(CH_SPACE);
        if (mode == 3) begin
            repeat ($urandom_range(1, 8)) reply_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if (mode == 4)
            push_str("Entering Passive Mode (");
        else begin
            repeat ($urandom_range(0, 2)) reply_q.push_back(other_char(CH_COMMA, CH_COMMA));
            reply_q.push_back(CH_OPEN);
        end
        // host address: four numbers, each closed by a comma
        repeat (4) begin
            push_str($sformatf("%0d", $urandom_range(0, 255)));
            reply_q.push_back(CH_COMMA);
        end
        push_field();
        reply_q.push_back(CH_COMMA);
        push_field();
        if (mode != 5)
            reply_q.push_back(CH_CLOSE);
    endfunction

    initial
    begin
        int next_pause;
        rst_n      = 1'b0;
        rx_valid   = 1'b0;
        rx_byte    = '0;
        idle_on    = 1'b0;
        sent       = 0;
        next_pause = PAUSE_EVERY;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty reply code, extreme code bytes with a padded high
        // field and a signed low field, then an overlong, oversized low field.
        send_text(" ");
        send_byte(8'hFF);
        send_byte(CH_NUL);
        send_text("a ,,,, 7,+1)");
        send_text("xyz ,,,,255,2550)");

        // Hold the sender until the block has caught up
        drain();

        // Random replies; idling switches on and off per reply and stops
        // entirely near the end.
        while (sent < BYTE_TARGET) begin
            if (sent >= BYTE_TARGET - CALM_TAIL)
                idle_on = 1'b0;
            else
                idle_on = ($urandom_range(0, 3) != 0);
            build_reply();
            foreach (reply_q[i])
                send_byte(reply_q[i]);
            if (sent >= next_pause) begin
                drain();
                next_pause += PAUSE_EVERY;
            end
        end

        drain();
        repeat (SETTLE) @(posedge clk);

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
